@@ src/pidgi_pkg.sv @@
// ----------------------------------------------------------------------------
// pidgi_pkg
// Shared types and constants of the gated-integral PID controller: register
// indexes, reset values, field widths and the stage-to-stage bundles.
// ----------------------------------------------------------------------------
package pidgi_pkg;

   // field widths
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned ERR_W    = SAMPLE_W + 1;
   localparam int unsigned DIFF_W   = ERR_W + 1;
   localparam int unsigned SUM_W    = 32;
   localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int unsigned PROD_D_W = GAIN_W + 1 + DIFF_W;
   localparam int unsigned PROD_I_W = GAIN_W + 1 + SUM_W;
   localparam int unsigned ACC_W    = PROD_I_W + 1;
   localparam int unsigned FRAC_W   = 8;
   localparam int unsigned CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 3'd5;

   // reset values
   localparam logic signed [SAMPLE_W-1:0] OUT_MIN_RST       = 16'sd0;
   localparam logic signed [SAMPLE_W-1:0] OUT_MAX_RST       = 16'sd255;
   localparam logic [SAMPLE_W-1:0]        SAMPLE_PERIOD_RST = 16'd50;

   // integral term only counts while |error| is below this
   localparam logic signed [ERR_W-1:0] ERR_GATE_HI = 17'sd3;
   localparam logic signed [ERR_W-1:0] ERR_GATE_LO = -17'sd3;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] out_min;
      logic signed [SAMPLE_W-1:0] out_max;
   } pidgi_limits_type;

   typedef struct packed {
      logic signed [PROD_P_W-1:0] p;
      logic signed [PROD_I_W-1:0] i;
      logic signed [PROD_D_W-1:0] d;
   } pidgi_prod_type;

endpackage

@@ src/pidgi_combine.sv @@
// ----------------------------------------------------------------------------
// pidgi_combine
// Adds the three gain products, drops the Q8.8 fraction with floor rounding
// and clamps to the output limits (upper limit first, lower limit wins).
// ----------------------------------------------------------------------------
module pidgi_combine (
   input  pidgi_pkg::pidgi_prod_type   prod,
   input  pidgi_pkg::pidgi_limits_type limits,
   output logic signed [15:0]          drive
);
   import pidgi_pkg::*;

   localparam int unsigned PID_W = ACC_W - FRAC_W;

   logic signed [ACC_W-1:0] acc;
   logic signed [PID_W-1:0] pid;
   logic signed [PID_W-1:0] lim_hi;
   logic signed [PID_W-1:0] lim_lo;
   logic signed [PID_W-1:0] clip_hi;

   // sum of products, arithmetic shift gives floor division by 256
   always_comb begin
      acc = ACC_W'(prod.p) + ACC_W'(prod.i) + ACC_W'(prod.d);
      pid = PID_W'(acc >>> FRAC_W);
   end

   // clamp against the upper limit, then the lower one
   always_comb begin
      lim_hi  = PID_W'(limits.out_max);
      lim_lo  = PID_W'(limits.out_min);
      clip_hi = (pid > lim_hi) ? lim_hi : pid;
      drive   = (clip_hi < lim_lo) ? limits.out_min : clip_hi[SAMPLE_W-1:0];
   end

endmodule

@@ src/pid_controller_gated_integral.sv @@
// ----------------------------------------------------------------------------
// pid_controller_gated_integral
// Sampled PID controller with Q8.8 gains, saturating error sum and an
// integral term that only counts for small errors.
// ----------------------------------------------------------------------------
// Takes one beat per clock while req_ready is high and gives at most one
// drive beat for it. A beat whose timestamp is not more than sample_period
// past the last update is dropped with no result and leaves the state alone.
// The datapath is four register levels: input register, error/sum register
// (where the controller state is updated, so the next beat already sees it),
// product register after the three gain multipliers, and the result register
// after the add, floor shift and clamp; a result shows on rsp_valid once its
// beat has passed these four registers. Each stage moves whenever the stage
// after it is empty or moving, so a waiting result does not stop new beats
// until the pipe is full. Limits and gains are to be written through the csr
// port only while no beat is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pid_controller_gated_integral (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [31:0]                      req_now_ms,
   input  logic signed [15:0]               req_measured,
   input  logic signed [15:0]               req_setpoint,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [15:0]               rsp_drive,
   input  logic                             csr_we,
   input  logic [pidgi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                      csr_wdata
);
   import pidgi_pkg::*;

   // configuration
   logic [GAIN_W-1:0]   gain_p_ff, gain_i_ff, gain_d_ff;
   logic [SAMPLE_W-1:0] sample_period_ff;
   pidgi_limits_type    limits_ff;

   // controller state
   logic [TIME_W-1:0]       last_time_ff;
   logic signed [ERR_W-1:0] prev_err_ff;
   logic signed [SUM_W-1:0] err_sum_ff;

   // input stage
   logic                       in_vld_ff;
   logic [TIME_W-1:0]          in_now_ff;
   logic signed [SAMPLE_W-1:0] in_meas_ff, in_sp_ff;

   // error stage
   logic                     er_vld_ff;
   logic signed [ERR_W-1:0]  er_err_ff;
   logic signed [DIFF_W-1:0] er_diff_ff;
   logic signed [SUM_W-1:0]  er_isum_ff;

   // product stage
   logic           pr_vld_ff;
   pidgi_prod_type pr_prod_ff;
   pidgi_prod_type pr_prod_in;

   // result stage
   logic                       out_vld_ff;
   logic signed [SAMPLE_W-1:0] out_drive_ff;
   logic signed [SAMPLE_W-1:0] out_drive_in;

   // stage advance
   logic adv_out, adv_pr, adv_er, adv_in;

   // error stage next values
   logic [TIME_W-1:0]        elapsed;
   logic                     due;
   logic                     update;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [DIFF_W-1:0] diff_in;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_in;
   logic                     gate_open;

   // pipeline flow
   always_comb begin
      adv_out   = !out_vld_ff || rsp_ready;
      adv_pr    = !pr_vld_ff || adv_out;
      adv_er    = !er_vld_ff || adv_pr;
      adv_in    = !in_vld_ff || adv_er;
      req_ready = adv_in;
      update    = in_vld_ff && adv_er && due;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         limits_ff.out_min <= OUT_MIN_RST;
         limits_ff.out_max <= OUT_MAX_RST;
         sample_period_ff  <= SAMPLE_PERIOD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN_P:        gain_p_ff         <= csr_wdata;
            CSR_GAIN_I:        gain_i_ff         <= csr_wdata;
            CSR_GAIN_D:        gain_d_ff         <= csr_wdata;
            CSR_OUT_MIN:       limits_ff.out_min <= csr_wdata;
            CSR_OUT_MAX:       limits_ff.out_max <= csr_wdata;
            CSR_SAMPLE_PERIOD: sample_period_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv_in) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_in && req_valid) begin
         in_now_ff  <= req_now_ms;
         in_meas_ff <= req_measured;
         in_sp_ff   <= req_setpoint;
      end
   end

   // sample gate, error, saturating sum and difference
   always_comb begin
      elapsed   = in_now_ff - last_time_ff;
      due       = elapsed > TIME_W'(sample_period_ff);
      err_in    = ERR_W'(in_sp_ff) - ERR_W'(in_meas_ff);
      diff_in   = DIFF_W'(err_in) - DIFF_W'(prev_err_ff);
      sum_wide  = (SUM_W + 1)'(err_sum_ff) + (SUM_W + 1)'(err_in);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                  : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
      gate_open = (err_in < ERR_GATE_HI) && (err_in > ERR_GATE_LO);
   end

   // controller state moves with each update
   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         prev_err_ff  <= '0;
         err_sum_ff   <= '0;
      end else if (update) begin
         last_time_ff <= in_now_ff;
         prev_err_ff  <= err_in;
         err_sum_ff   <= sum_in;
      end
   end

   // error register
   always_ff @(posedge clock) begin
      if (reset) begin
         er_vld_ff <= 1'b0;
      end else if (adv_er) begin
         er_vld_ff <= in_vld_ff && due;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         er_err_ff  <= err_in;
         er_diff_ff <= diff_in;
         er_isum_ff <= gate_open ? sum_in : '0;
      end
   end

   // gain products
   always_comb begin
      pr_prod_in.p = PROD_P_W'($signed({1'b0, gain_p_ff})) * PROD_P_W'(er_err_ff);
      pr_prod_in.i = PROD_I_W'($signed({1'b0, gain_i_ff})) * PROD_I_W'(er_isum_ff);
      pr_prod_in.d = PROD_D_W'($signed({1'b0, gain_d_ff})) * PROD_D_W'(er_diff_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else if (adv_pr) begin
         pr_vld_ff <= er_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_pr && er_vld_ff) begin
         pr_prod_ff <= pr_prod_in;
      end
   end

   // sum, scale and clamp
   pidgi_combine u_combine (
      .prod   (pr_prod_ff),
      .limits (limits_ff),
      .drive  (out_drive_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv_out) begin
         out_vld_ff <= pr_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && pr_vld_ff) begin
         out_drive_ff <= out_drive_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_drive = out_drive_ff;

endmodule

@@ src/pidgi_checker.sv @@
// ----------------------------------------------------------------------------
// pidgi_checker
// Port-level checks of the PID controller: reset, result hold, the promise
// that an empty or moving result register never blocks the input, and csr
// writes only while the block is quiet.
// ----------------------------------------------------------------------------
module pidgi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_drive,
   input logic               csr_we
);

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive))
      else $error("result beat changed while stalled");

   // with the result register empty the pipe always has room
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty result register");

   // a taken result moves every stage, so the input has room too
   a_ready_after_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input blocked while a result beat is taken");

   // settings only change while no result waits and no request is offered
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_we |-> !rsp_valid && !req_valid)
      else $error("csr write while beats are in flight");

endmodule

bind pid_controller_gated_integral pidgi_checker u_pidgi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_drive (rsp_drive),
   .csr_we    (csr_we)
);
